// ===== design/sparse_triplet_matrix_add_top_macros.svh =====
// assertion macros for the sparse triplet matrix adder
// used only by sparse_triplet_matrix_add_top, expects i_clk and i_rst_n in scope
`ifndef SPARSE_TRIPLET_MATRIX_ADD_TOP_MACROS_SVH
`define SPARSE_TRIPLET_MATRIX_ADD_TOP_MACROS_SVH

// same-cycle implication
`define STMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/stma_pkg.sv =====
// shared types and constants for the sparse triplet matrix adder
// no dependencies
package stma_pkg;

    localparam int unsigned DIM_W      = 9;
    localparam int unsigned POS_W      = 8;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam logic [DIM_W-1:0] DIM_RESET = 9'd4;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_RUN    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_LOAD_OK   = 3'd0,
        ST_LOAD_FULL = 3'd1,
        ST_SUM       = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        t_status                 status;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic mismatch;
        logic step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic size_match;
        logic merge_done;
        logic out_free;
    } t_stat;

endpackage

// ===== design/stma_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module stma_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/stma_ctrl.sv =====
// controller for the sparse triplet matrix adder: input acceptance and merge sequencing
// depends on stma_pkg
module stma_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  stma_pkg::t_op  i_op,
    input  stma_pkg::t_stat i_stat,
    output logic           o_stall,
    output stma_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_MERGE = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_stall = !((r_state == S_IDLE) && i_stat.out_free);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        stma_pkg::OP_LOAD_A: o_cmd.load_a = 1'b1;
                        stma_pkg::OP_LOAD_B: o_cmd.load_b = 1'b1;
                        stma_pkg::OP_RUN: begin
                            if (i_stat.size_match) begin
                                n_state = S_MERGE;
                            end else begin
                                o_cmd.mismatch = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MERGE: begin
                if (i_stat.out_free) begin
                    if (i_stat.merge_done) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/stma_dp.sv =====
// datapath for the sparse triplet matrix adder: dimension registers, entry lists,
// merge step, pending entry and output register; depends on stma_pkg and stma_ram
module stma_dp #(
    parameter int unsigned MAX_ENTRIES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  stma_pkg::t_cmd                   i_cmd,
    output stma_pkg::t_stat                  o_stat,
    input  logic [stma_pkg::POS_W-1:0]       i_row,
    input  logic [stma_pkg::POS_W-1:0]       i_col,
    input  logic signed [stma_pkg::VAL_W-1:0] i_value,
    input  logic                             i_cfg_we,
    input  logic [stma_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [stma_pkg::DIM_W-1:0]       i_cfg_data,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output stma_pkg::t_result                o_result
);

    localparam int unsigned IDX_W = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned ENT_W = $bits(stma_pkg::t_entry);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    logic [stma_pkg::DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [CNT_W-1:0] r_a_cnt, r_b_cnt, r_i, r_j;
    logic [CNT_W-1:0] n_a_cnt, n_b_cnt, n_i, n_j;
    logic              r_pend_valid, n_pend_valid;
    stma_pkg::t_entry  r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    stma_pkg::t_result r_out, n_out;

    logic [ENT_W-1:0]  a_rdata, b_rdata;
    stma_pkg::t_entry  a_ent, b_ent, wr_ent, cand;
    logic              a_full, b_full, a_has, b_has;
    logic              take_a, take_b, keep;
    logic [2*stma_pkg::POS_W-1:0] key_a, key_b;
    logic signed [stma_pkg::VAL_W:0]   sum_w;
    logic signed [stma_pkg::VAL_W-1:0] sum_sat;

    assign wr_ent = '{row: i_row, col: i_col, value: i_value};

    stma_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_a && !a_full),
        .i_waddr (r_a_cnt[IDX_W-1:0]),
        .i_wdata (wr_ent),
        .i_raddr (n_i[IDX_W-1:0]),
        .o_rdata (a_rdata)
    );

    stma_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_b && !b_full),
        .i_waddr (r_b_cnt[IDX_W-1:0]),
        .i_wdata (wr_ent),
        .i_raddr (n_j[IDX_W-1:0]),
        .o_rdata (b_rdata)
    );

    assign a_ent  = stma_pkg::t_entry'(a_rdata);
    assign b_ent  = stma_pkg::t_entry'(b_rdata);
    assign a_full = (r_a_cnt == CNT_MAX);
    assign b_full = (r_b_cnt == CNT_MAX);
    assign a_has  = (r_i < r_a_cnt);
    assign b_has  = (r_j < r_b_cnt);
    assign key_a  = {a_ent.row, a_ent.col};
    assign key_b  = {b_ent.row, b_ent.col};
    assign take_a = a_has && (!b_has || (key_a < key_b));
    assign take_b = !take_a && b_has && (!a_has || (key_b < key_a));

    // saturating sum for equal positions
    assign sum_w = {a_ent.value[stma_pkg::VAL_W-1], a_ent.value}
                 + {b_ent.value[stma_pkg::VAL_W-1], b_ent.value};
    always_comb begin
        if (sum_w[stma_pkg::VAL_W] != sum_w[stma_pkg::VAL_W-1]) begin
            sum_sat = sum_w[stma_pkg::VAL_W]
                    ? {1'b1, {(stma_pkg::VAL_W-1){1'b0}}}
                    : {1'b0, {(stma_pkg::VAL_W-1){1'b1}}};
        end else begin
            sum_sat = sum_w[stma_pkg::VAL_W-1:0];
        end
    end

    always_comb begin
        cand.row   = take_b ? b_ent.row : a_ent.row;
        cand.col   = take_b ? b_ent.col : a_ent.col;
        cand.value = take_a ? a_ent.value : (take_b ? b_ent.value : sum_sat);
        keep       = take_a || take_b || (sum_sat != '0);
    end

    always_comb begin
        n_a_cnt      = r_a_cnt;
        n_b_cnt      = r_b_cnt;
        n_i          = r_i;
        n_j          = r_j;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        if (i_cmd.load_a || i_cmd.load_b) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.last  = 1'b1;
            if (i_cmd.load_a) begin
                if (a_full) begin
                    n_out.status = stma_pkg::ST_LOAD_FULL;
                end else begin
                    n_out.status = stma_pkg::ST_LOAD_OK;
                    n_a_cnt      = r_a_cnt + CNT_W'(1);
                end
            end else begin
                if (b_full) begin
                    n_out.status = stma_pkg::ST_LOAD_FULL;
                end else begin
                    n_out.status = stma_pkg::ST_LOAD_OK;
                    n_b_cnt      = r_b_cnt + CNT_W'(1);
                end
            end
        end
        if (i_cmd.mismatch) begin
            n_out_valid  = 1'b1;
            n_out        = '0;
            n_out.status = stma_pkg::ST_MISMATCH;
            n_out.last   = 1'b1;
            n_a_cnt      = '0;
            n_b_cnt      = '0;
        end
        if (i_cmd.step) begin
            if (!take_b) begin
                n_i = r_i + CNT_W'(1);
            end
            if (!take_a) begin
                n_j = r_j + CNT_W'(1);
            end
            if (keep) begin
                n_pend       = cand;
                n_pend_valid = 1'b1;
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: stma_pkg::ST_SUM, row: r_pend.row, col: r_pend.col,
                              value: r_pend.value, last: 1'b0};
                end
            end
        end
        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
            if (r_pend_valid) begin
                n_out = '{status: stma_pkg::ST_SUM, row: r_pend.row, col: r_pend.col,
                          value: r_pend.value, last: 1'b1};
            end else begin
                n_out        = '0;
                n_out.status = stma_pkg::ST_EMPTY;
                n_out.last   = 1'b1;
            end
            n_pend_valid = 1'b0;
            n_a_cnt      = '0;
            n_b_cnt      = '0;
            n_i          = '0;
            n_j          = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows     <= stma_pkg::DIM_RESET;
            r_a_cols     <= stma_pkg::DIM_RESET;
            r_b_rows     <= stma_pkg::DIM_RESET;
            r_b_cols     <= stma_pkg::DIM_RESET;
            r_a_cnt      <= '0;
            r_b_cnt      <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (stma_pkg::t_cfg_idx'(i_cfg_index))
                    stma_pkg::CFG_A_ROWS: r_a_rows <= i_cfg_data;
                    stma_pkg::CFG_A_COLS: r_a_cols <= i_cfg_data;
                    stma_pkg::CFG_B_ROWS: r_b_rows <= i_cfg_data;
                    stma_pkg::CFG_B_COLS: r_b_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            r_a_cnt      <= n_a_cnt;
            r_b_cnt      <= n_b_cnt;
            r_i          <= n_i;
            r_j          <= n_j;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_stat.size_match = (r_a_rows == r_b_rows) && (r_a_cols == r_b_cols);
    assign o_stat.merge_done = !a_has && !b_has;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_result          = r_out;

endmodule

// ===== design/sparse_triplet_matrix_add_top.sv =====
// top level of the sparse triplet matrix adder
// depends on stma_pkg, stma_ctrl, stma_dp, stma_ram and the assertion macro header
//
//  channel   handshake                 payload
//  input     i_valid / o_stall         i_operation, i_row, i_col, i_value
//  result    o_valid / i_stall         o_status, o_out_row, o_out_col, o_out_value, o_last
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a load's transaction lands in the output register
// a run with matching dimensions does one merge step per cycle through the two list rams
// while the output register is free, then flushes the held entry with last; a size mismatch is reported instead
// a stalled result holds back the merge and further input
// reset clears counts and sets all dimensions to four; list contents need no clearing
`include "sparse_triplet_matrix_add_top_macros.svh"

module sparse_triplet_matrix_add_top #(
    parameter int unsigned MAX_ENTRIES = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_operation,
    input  logic [stma_pkg::POS_W-1:0]         i_row,
    input  logic [stma_pkg::POS_W-1:0]         i_col,
    input  logic signed [stma_pkg::VAL_W-1:0]  i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [2:0]                         o_status,
    output logic [stma_pkg::POS_W-1:0]         o_out_row,
    output logic [stma_pkg::POS_W-1:0]         o_out_col,
    output logic signed [stma_pkg::VAL_W-1:0]  o_out_value,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stma_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stma_pkg::DIM_W-1:0]         i_cfg_data
);

    stma_pkg::t_cmd    w_cmd;
    stma_pkg::t_stat   w_stat;
    stma_pkg::t_result w_result;
    logic              w_push;
    logic              w_merging;
    logic              w_run_closed;

    assign o_cfg_ready = 1'b1;

    stma_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (stma_pkg::t_op'(i_operation)),
        .i_stat  (w_stat),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    stma_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_result    (w_result)
    );

    assign o_status    = w_result.status;
    assign o_out_row   = w_result.row;
    assign o_out_col   = w_result.col;
    assign o_out_value = w_result.value;
    assign o_last      = w_result.last;

    assign w_push       = w_cmd.load_a || w_cmd.load_b || w_cmd.mismatch
                        || w_cmd.step || w_cmd.finish;
    assign w_merging    = w_cmd.step || w_cmd.finish;
    assign w_run_closed = w_stat.merge_done && o_valid && o_last;

    `STMA_ASSERT_NOW(a_push_slot_free, w_push, w_stat.out_free, "push into busy output register")
    `STMA_ASSERT_NOW(a_merge_blocks_input, w_merging, o_stall, "input taken during merge")
    `STMA_ASSERT_NEXT(a_finish_clears_lists, w_cmd.finish, w_run_closed, "run end left state")

endmodule

// ===== tb/sv/stma_tb_pkg.sv =====
// result tracker for the sparse triplet matrix adder testbench: keeps its own lists and
// dimensions, predicts the results of every accepted transaction and checks them in order
// depends on stma_pkg
package stma_tb_pkg;
    import stma_pkg::*;

    localparam int unsigned LIST_DEPTH = 32;

    class sparse_sum_checker;
        logic [DIM_W-1:0] dims [4];
        t_entry list_a [$];
        t_entry list_b [$];
        t_result pending_sums [$];
        int unsigned errors;
        int unsigned seen;

        function new();
            foreach (dims[i]) dims[i] = DIM_RESET;
            errors = 0;
            seen = 0;
        endfunction

        function void set_dim(t_cfg_idx idx, logic [DIM_W-1:0] data);
            dims[idx] = data;
        endfunction

        function void push_result(t_status st, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                  logic signed [VAL_W-1:0] value, logic last);
            t_result r;
            r.status = st;
            r.row = row;
            r.col = col;
            r.value = value;
            r.last = last;
            pending_sums.push_back(r);
        endfunction

        // merge both lists in row-then-column order, summing equal positions, or report a dimension mismatch
        function void sum_lists();
            int unsigned ia;
            int unsigned ib;
            int unsigned first;
            logic [2*POS_W-1:0] ka;
            logic [2*POS_W-1:0] kb;
            logic [VAL_W:0] wide;
            logic signed [VAL_W-1:0] sat;
            t_result r;
            ia = 0;
            ib = 0;
            ka = '0;
            kb = '0;
            first = pending_sums.size();
            if (dims[CFG_A_ROWS] != dims[CFG_B_ROWS] || dims[CFG_A_COLS] != dims[CFG_B_COLS]) begin
                push_result(ST_MISMATCH, '0, '0, '0, 1'b1);
            end else begin
                while (ia < list_a.size() || ib < list_b.size()) begin
                    if (ia < list_a.size()) ka = {list_a[ia].row, list_a[ia].col};
                    if (ib < list_b.size()) kb = {list_b[ib].row, list_b[ib].col};
                    if (ib >= list_b.size() || (ia < list_a.size() && ka < kb)) begin
                        push_result(ST_SUM, list_a[ia].row, list_a[ia].col, list_a[ia].value,
                                    1'b0);
                        ia++;
                    end else if (ia >= list_a.size() || kb < ka) begin
                        push_result(ST_SUM, list_b[ib].row, list_b[ib].col, list_b[ib].value,
                                    1'b0);
                        ib++;
                    end else begin
                        wide = {list_a[ia].value[VAL_W-1], list_a[ia].value}
                             + {list_b[ib].value[VAL_W-1], list_b[ib].value};
                        if (wide[VAL_W] != wide[VAL_W-1])
                            sat = wide[VAL_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        else
                            sat = wide[VAL_W-1:0];
                        if (sat != 0)
                            push_result(ST_SUM, list_a[ia].row, list_a[ia].col, sat, 1'b0);
                        ia++;
                        ib++;
                    end
                end
                if (pending_sums.size() == first) begin
                    push_result(ST_EMPTY, '0, '0, '0, 1'b1);
                end else begin
                    r = pending_sums.pop_back();
                    r.last = 1'b1;
                    pending_sums.push_back(r);
                end
            end
            list_a.delete();
            list_b.delete();
        endfunction

        function void note_item(t_op op, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                logic signed [VAL_W-1:0] value);
            t_entry e;
            e.row = row;
            e.col = col;
            e.value = value;
            case (op)
                OP_LOAD_A: begin
                    if (list_a.size() >= LIST_DEPTH) begin
                        push_result(ST_LOAD_FULL, '0, '0, '0, 1'b1);
                    end else begin
                        list_a.push_back(e);
                        push_result(ST_LOAD_OK, '0, '0, '0, 1'b1);
                    end
                end
                OP_LOAD_B: begin
                    if (list_b.size() >= LIST_DEPTH) begin
                        push_result(ST_LOAD_FULL, '0, '0, '0, 1'b1);
                    end else begin
                        list_b.push_back(e);
                        push_result(ST_LOAD_OK, '0, '0, '0, 1'b1);
                    end
                end
                OP_RUN: sum_lists();
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at result %0d: %s", seen, msg);
        endtask

        task check_result(t_result got);
            t_result want;
            seen++;
            if (pending_sums.size() == 0) begin
                report("result transaction with nothing expected");
                return;
            end
            want = pending_sums.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.row !== want.row)
                report($sformatf("row %0d, expected %0d", got.row, want.row));
            if (got.col !== want.col)
                report($sformatf("col %0d, expected %0d", got.col, want.col));
            if (got.value !== want.value)
                report($sformatf("value %0d, expected %0d", got.value, want.value));
            if (got.last !== want.last)
                report($sformatf("last %0b, expected %0b", got.last, want.last));
        endtask
    endclass

endpackage

// ===== tb/sv/tb_sparse_triplet_matrix_add_top.sv =====
// testbench top for sparse_triplet_matrix_add_top: directed and random load/run transactions
// with random idling on both channels, results checked against a predicted merge
// depends on stma_pkg, stma_tb_pkg and the adder rtl
module tb_sparse_triplet_matrix_add_top;
    import stma_pkg::*;
    import stma_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned ITEM_TARGET   = 260;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      o_stall;
    logic [1:0]                i_operation = OP_NONE;
    logic [POS_W-1:0]          i_row       = '0;
    logic [POS_W-1:0]          i_col       = '0;
    logic signed [VAL_W-1:0]   i_value     = '0;
    logic                      o_valid;
    logic                      i_stall     = 1'b0;
    logic [2:0]                o_status;
    logic [POS_W-1:0]          o_out_row;
    logic [POS_W-1:0]          o_out_col;
    logic signed [VAL_W-1:0]   o_out_value;
    logic                      o_last;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = CFG_A_ROWS;
    logic [DIM_W-1:0]          i_cfg_data  = '0;

    sparse_sum_checker sums;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    bit calm = 1'b0;

    sparse_triplet_matrix_add_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_sparse_triplet_matrix_add_top: errors");
        $finish;
    end

    function automatic int unsigned idle_draw();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic signed [VAL_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(t_op op, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                             logic signed [VAL_W-1:0] value);
        int unsigned gap;
        gap = idle_draw();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_operation = op;
        i_row = row;
        i_col = col;
        i_value = value;
        do @(posedge i_clk); while (o_stall);
        sums.note_item(op, row, col, value);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // drop valid, wait for every expected result, then let the block settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sums.pending_sums.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_dim(t_cfg_idx idx, logic [DIM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sums.set_dim(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_dims(logic [DIM_W-1:0] ar, logic [DIM_W-1:0] ac,
                            logic [DIM_W-1:0] br, logic [DIM_W-1:0] bc);
        write_dim(CFG_A_ROWS, ar);
        write_dim(CFG_A_COLS, ac);
        write_dim(CFG_B_ROWS, br);
        write_dim(CFG_B_COLS, bc);
    endtask

    task automatic pick_dims();
        logic [DIM_W-1:0] r;
        logic [DIM_W-1:0] c;
        r = $urandom_range(0, 511);
        c = $urandom_range(0, 511);
        case ($urandom_range(0, 7))
            0: set_dims(9'd256, 9'd256, 9'd256, 9'd256);
            1: set_dims(9'd1, 9'd1, 9'd1, 9'd1);
            2: set_dims(9'h1FF, 9'h000, 9'h1FF, 9'h000);
            3: set_dims(r, c, r ^ (9'd1 << $urandom_range(0, 8)), c);
            4: set_dims(r, c, r, c ^ (9'd1 << $urandom_range(0, 8)));
            default: set_dims(r, c, r, c);
        endcase
    endtask

    // sorted batches share positions between the lists so that sums, zero sums and
    // saturation all occur; unsorted batches use the full coordinate range
    task automatic send_batch(int unsigned na, int unsigned nb, bit sorted, bit wide);
        t_entry ta [$];
        t_entry tb [$];
        t_entry ea;
        t_entry eb;
        int unsigned key;
        int unsigned pick;
        if (sorted) begin
            key = $urandom_range(0, wide ? 4000 : 20);
            while ((ta.size() < na || tb.size() < nb) && key <= 16'hFFFF) begin
                pick = $urandom_range(0, 2);
                if (ta.size() >= na)
                    pick = 1;
                else if (tb.size() >= nb)
                    pick = 0;
                ea.row = key[15:8];
                ea.col = key[7:0];
                ea.value = draw_value();
                eb = ea;
                eb.value = ($urandom_range(0, 2) == 0) ? -ea.value : draw_value();
                if (pick != 1)
                    ta.push_back(ea);
                if (pick != 0)
                    tb.push_back(eb);
                key += $urandom_range(1, wide ? 3000 : 3);
            end
        end else begin
            repeat (na) begin
                ea.row = $urandom_range(0, 255);
                ea.col = $urandom_range(0, 255);
                ea.value = draw_value();
                ta.push_back(ea);
            end
            repeat (nb) begin
                eb.row = $urandom_range(0, 255);
                eb.col = $urandom_range(0, 255);
                eb.value = draw_value();
                tb.push_back(eb);
            end
        end
        while (ta.size() + tb.size() > 0) begin
            if ($urandom_range(0, 19) == 0)
                send_item(OP_NONE, $urandom, $urandom, $urandom);
            if (tb.size() == 0 || (ta.size() != 0 && $urandom_range(0, 1) == 0)) begin
                ea = ta.pop_front();
                send_item(OP_LOAD_A, ea.row, ea.col, ea.value);
            end else begin
                eb = tb.pop_front();
                send_item(OP_LOAD_B, eb.row, eb.col, eb.value);
            end
        end
        if ($urandom_range(0, 5) == 0)
            wait_drained();
        if ($urandom_range(0, 7) != 0)
            send_item(OP_RUN, $urandom, $urandom, $urandom);
    endtask

    initial begin
        int unsigned hold;
        t_result got;
        @(posedge i_rst_n);
        forever begin
            hold = idle_draw();
            repeat (hold) begin
                @(negedge i_clk);
                i_stall = 1'b1;
            end
            @(negedge i_clk);
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got.status = t_status'(o_status);
            got.row = o_out_row;
            got.col = o_out_col;
            got.value = o_out_value;
            got.last = o_last;
            sums.check_result(got);
        end
    end

    initial begin
        bit full;
        sums = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty run, then saturation both ways, a zero sum and interleaved positions
        send_item(OP_RUN, 8'h00, 8'h00, 32'sd0);
        send_item(OP_LOAD_A, 8'd0, 8'd0, 32'sh7FFF_FFFF);
        send_item(OP_LOAD_B, 8'd0, 8'd0, 32'sd1);
        send_item(OP_LOAD_A, 8'd0, 8'd1, -32'sd5);
        send_item(OP_LOAD_B, 8'd0, 8'd1, 32'sd5);
        send_item(OP_LOAD_A, 8'd3, 8'd2, 32'sd7);
        send_item(OP_LOAD_B, 8'd1, 8'd0, 32'sh5555_5555);
        send_item(OP_LOAD_A, 8'd255, 8'd255, 32'sh8000_0000);
        send_item(OP_LOAD_B, 8'd255, 8'd255, -32'sd1);
        send_item(OP_NONE, 8'hAA, 8'h55, 32'shAAAA_AAAA);
        send_item(OP_RUN, 8'hFF, 8'hFF, 32'shFFFF_FFFF);
        // tail of b left over
        send_item(OP_LOAD_A, 8'd2, 8'd2, 32'sd1);
        send_item(OP_LOAD_B, 8'd2, 8'd3, 32'shAAAA_AAAA);
        send_item(OP_LOAD_B, 8'd200, 8'd17, -32'sd100);
        send_item(OP_RUN, 8'h55, 8'hAA, 32'sh5555_5555);
        // tail of a left over
        send_item(OP_LOAD_A, 8'd9, 8'd9, 32'sd1);
        send_item(OP_LOAD_A, 8'd10, 8'd0, 32'sd2);
        send_item(OP_LOAD_B, 8'd0, 8'd5, 32'sd3);
        send_item(OP_RUN, 8'd0, 8'd0, 32'sd0);
        // every sum cancels
        send_item(OP_LOAD_A, 8'd5, 8'd5, 32'sd9);
        send_item(OP_LOAD_B, 8'd5, 8'd5, -32'sd9);
        send_item(OP_RUN, 8'd0, 8'd0, 32'sd0);
        wait_drained();
        set_dims(9'h1FF, 9'h000, 9'h1FF, 9'h001);
        send_item(OP_LOAD_A, 8'd7, 8'd7, 32'sd3);
        send_item(OP_RUN, 8'd0, 8'd0, 32'sd0);
        wait_drained();
        set_dims(9'd256, 9'd1, 9'd256, 9'd1);
        send_item(OP_RUN, 8'd0, 8'd0, 32'sd0);

        while (items_sent < ITEM_TARGET) begin
            wait_drained();
            pick_dims();
            calm = ($urandom_range(0, 3) == 0);
            repeat (3) begin
                full = ($urandom_range(0, 7) == 0);
                send_batch(full ? $urandom_range(30, 36) : $urandom_range(0, 8),
                           full ? $urandom_range(20, 36) : $urandom_range(0, 8),
                           $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
            end
        end
        calm = 1'b0;

        wait_drained();
        if (sums.errors == 0)
            $display("tb_sparse_triplet_matrix_add_top: clean");
        else
            $display("tb_sparse_triplet_matrix_add_top: errors");
        $finish;
    end

endmodule
